### rtl/core/hcsa_pkg.sv
// Shared widths, constants and divider handshake types for the histogram
// chi-square accumulator. Has no dependencies; every other file in rtl/core
// refers to it by scoped names.
`default_nettype none

package hcsa_pkg;

    // Field widths of the channels and the configuration registers.
    localparam int BIN_W       = 12;
    localparam int CONTENT_W   = 32;
    localparam int REG_W       = 13;
    localparam int SUM_W       = 56;
    localparam int CFG_INDEX_W = 1;

    // Digit-serial arithmetic: two bits are handled per cycle.
    localparam int DIGIT_W     = 2;
    localparam int PROD_W      = 2 * CONTENT_W;
    localparam int MULT_STEPS  = CONTENT_W / DIGIT_W;
    localparam int MULT_CNT_W  = $clog2(MULT_STEPS);

    // The term is (d*d) * 2^FRAC_SHIFT / observed, giving a UQ48.8 value.
    localparam int FRAC_SHIFT  = 8;
    localparam int QUO_W       = SUM_W;
    localparam int SQ_TOP_W    = PROD_W + FRAC_SHIFT - QUO_W;
    localparam int DIV_STEPS   = QUO_W / DIGIT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Configuration register indices.
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_BIN  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_BIN = 1'b1;

    // Request to the shared serial divider.
    typedef struct packed {
        logic                 start;
        logic [CONTENT_W-1:0] rem_init;
        logic [CONTENT_W-1:0] divisor;
        logic [QUO_W-1:0]     dividend;
    } div_req_t;

    // Status returned by the shared serial divider.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/hcsa_if.sv
// Valid/ready channel interfaces for bin pair items and result items.
// Depends on hcsa_pkg for the field widths.
`default_nettype none

interface hcsa_in_if;
    logic                           valid;
    logic                           ready;
    logic [hcsa_pkg::BIN_W-1:0]     bin_index;
    logic [hcsa_pkg::CONTENT_W-1:0] observed;
    logic [hcsa_pkg::CONTENT_W-1:0] compared;
    logic                           last_bin;

    modport source (output valid, bin_index, observed, compared, last_bin, input ready);
    modport sink   (input valid, bin_index, observed, compared, last_bin, output ready);
endinterface

interface hcsa_out_if;
    logic                       valid;
    logic                       ready;
    logic [hcsa_pkg::SUM_W-1:0] total_chi_square;
    logic [hcsa_pkg::SUM_W-1:0] reduced_chi_square;
    logic                       no_degrees_of_freedom;
    logic                       saturated;

    modport source (output valid, total_chi_square, reduced_chi_square,
                    no_degrees_of_freedom, saturated, input ready);
    modport sink   (input valid, total_chi_square, reduced_chi_square,
                    no_degrees_of_freedom, saturated, output ready);
endinterface

`default_nettype wire

### rtl/core/hcsa_div.sv
// Radix-4 restoring divider, two quotient bits per cycle, shared by the
// bin term and the reduced value. Depends on hcsa_pkg.
`default_nettype none

module hcsa_div (
    input  logic                clk,
    input  logic                rst_n,
    input  hcsa_pkg::div_req_t  req,
    output hcsa_pkg::div_stat_t stat
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [hcsa_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [hcsa_pkg::CONTENT_W-1:0]      rem_reg;
    logic [hcsa_pkg::CONTENT_W-1:0]      dvs_reg;
    logic [hcsa_pkg::QUO_W-1:0]          num_reg;

    logic [hcsa_pkg::CONTENT_W:0]        r1;
    logic [hcsa_pkg::CONTENT_W:0]        r1s;
    logic [hcsa_pkg::CONTENT_W:0]        r2;
    logic [hcsa_pkg::CONTENT_W:0]        r2s;
    logic                                ge1;
    logic                                ge2;

    // Two dependent subtract-and-restore steps per cycle.
    always_comb
    begin
        r1  = {rem_reg, num_reg[hcsa_pkg::QUO_W-1]};
        ge1 = r1 >= {1'b0, dvs_reg};
        r1s = ge1 ? (r1 - {1'b0, dvs_reg}) : r1;
        r2  = {r1s[hcsa_pkg::CONTENT_W-1:0], num_reg[hcsa_pkg::QUO_W-2]};
        ge2 = r2 >= {1'b0, dvs_reg};
        r2s = ge2 ? (r2 - {1'b0, dvs_reg}) : r2;
    end

    // Control: busy while the steps run, then a one-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == hcsa_pkg::DIV_CNT_W'(hcsa_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + hcsa_pkg::DIV_CNT_W'(1);
                end
            end
        end
    end

    // Datapath: the dividend shifts out at the top while quotient bits
    // shift in at the bottom, so the register holds the quotient at the end.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            dvs_reg <= req.divisor;
            num_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= r2s[hcsa_pkg::CONTENT_W-1:0];
            num_reg <= {num_reg[hcsa_pkg::QUO_W-3:0], ge1, ge2};
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = num_reg;

    // A start is always followed by a busy period.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider did not go busy after start");

    // Done only ends a busy period.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a preceding busy period");

    // No new request arrives while a division is running.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    // The step counter rests at zero when idle.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == '0))
        else $error("divider step counter not cleared when idle");

endmodule

`default_nettype wire

### rtl/core/histogram_chi_square_accumulator_unit.sv
// Histogram chi-square accumulator top level.
// Depends on hcsa_pkg, the channel interfaces in hcsa_if and hcsa_div.
//
// Usage:
//   bin_pair carries one bin pair per item (bin_index, observed, compared,
//   last_bin). result carries one item per histogram, produced on the item
//   marked last_bin: the UQ48.8 total, the total divided by
//   high_bin - low_bin - 1, and the two flags.
//   low_bin and high_bin are written through cfg_write/cfg_index/cfg_data.
// Sequence:
//   A bin outside [low_bin, high_bin) or with zero observed content is
//   taken in S_IDLE alone. An included bin passes through the
//   two-bit-per-cycle square of |observed - compared| (S_MULT), the shared
//   radix-4 divider (S_TDIV) and accumulation (S_ACCUM). The last bin,
//   when high_bin > low_bin + 1, adds a second divider pass for the
//   reduced value (S_RDIV); then the output register is loaded (S_EMIT).
//   A new bin is taken only once the previous one is through.
// Reset clears the sum and the clip flag and sets low_bin to 0 and
// high_bin to BIN_COUNT. A result waits in the output register while the
// receiver stalls; following bins are still taken and summed, and only the
// next result waits until the register is free. The sum clears once a
// result is loaded.
`default_nettype none

module histogram_chi_square_accumulator_unit #(
    parameter int BIN_COUNT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    hcsa_in_if.sink                           bin_pair,
    hcsa_out_if.source                        result,
    input  logic                              cfg_write,
    input  logic [hcsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hcsa_pkg::REG_W-1:0]        cfg_data
);

    localparam logic [hcsa_pkg::REG_W-1:0] HIGH_RESET =
        hcsa_pkg::REG_W'(BIN_COUNT % (2 ** hcsa_pkg::REG_W));

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_TDIV,
        S_ACCUM,
        S_RDIV,
        S_EMIT
    } state_t;

    state_t                             state_reg;
    logic [hcsa_pkg::REG_W-1:0]         low_reg;
    logic [hcsa_pkg::REG_W-1:0]         high_reg;
    logic [hcsa_pkg::SUM_W-1:0]         chi_sum_reg;
    logic                               clip_reg;
    logic                               last_reg;
    logic [hcsa_pkg::CONTENT_W-1:0]     obs_reg;
    logic [hcsa_pkg::CONTENT_W-1:0]     mcand_reg;
    logic [hcsa_pkg::CONTENT_W-1:0]     mplier_reg;
    logic [hcsa_pkg::PROD_W-1:0]        prod_reg;
    logic [hcsa_pkg::MULT_CNT_W-1:0]    cnt_reg;
    logic                               div_start_reg;
    logic                               out_valid_reg;
    logic [hcsa_pkg::SUM_W-1:0]         total_reg;
    logic [hcsa_pkg::SUM_W-1:0]         reduced_reg;
    logic                               nodof_reg;
    logic                               sat_reg;

    logic [hcsa_pkg::CONTENT_W-1:0]     d_in;
    logic                               include_bin;
    logic                               dof_ok;
    logic [hcsa_pkg::REG_W-1:0]         dof_div;
    logic [hcsa_pkg::CONTENT_W+1:0]     partial;
    logic [hcsa_pkg::CONTENT_W+1:0]     mult_sum;
    logic [hcsa_pkg::PROD_W-1:0]        prod_next;
    logic                               term_sat;
    logic [hcsa_pkg::SUM_W-1:0]         term;
    logic [hcsa_pkg::SUM_W:0]           acc_sum;

    hcsa_pkg::div_req_t                 div_req;
    hcsa_pkg::div_stat_t                div_stat;

    // Input qualification: absolute difference and range test.
    always_comb
    begin
        d_in = (bin_pair.observed >= bin_pair.compared)
             ? (bin_pair.observed - bin_pair.compared)
             : (bin_pair.compared - bin_pair.observed);
        include_bin = ({1'b0, bin_pair.bin_index} >= low_reg)
                   && ({1'b0, bin_pair.bin_index} < high_reg)
                   && (bin_pair.observed != '0);
    end

    // Degrees of freedom from the configured range.
    assign dof_ok  = {1'b0, high_reg} > ({1'b0, low_reg} + (hcsa_pkg::REG_W + 1)'(1));
    assign dof_div = high_reg - low_reg - hcsa_pkg::REG_W'(1);

    // Shift-add squarer: one two-bit digit of the multiplier per cycle.
    always_comb
    begin
        case (mplier_reg[hcsa_pkg::DIGIT_W-1:0])
            2'd0:    partial = '0;
            2'd1:    partial = {2'b00, mcand_reg};
            2'd2:    partial = {1'b0, mcand_reg, 1'b0};
            2'd3:    partial = {2'b00, mcand_reg} + {1'b0, mcand_reg, 1'b0};
            default: partial = '0;
        endcase
        mult_sum  = {2'b00, prod_reg[hcsa_pkg::PROD_W-1:hcsa_pkg::CONTENT_W]} + partial;
        prod_next = {mult_sum, prod_reg[hcsa_pkg::CONTENT_W-1:hcsa_pkg::DIGIT_W]};
    end

    // Term with saturation, and the clipped accumulation.
    always_comb
    begin
        term_sat = {{(hcsa_pkg::CONTENT_W-hcsa_pkg::SQ_TOP_W){1'b0}},
                    prod_reg[hcsa_pkg::PROD_W-1 -: hcsa_pkg::SQ_TOP_W]} >= obs_reg;
        term     = term_sat ? hcsa_pkg::SUM_MAX : div_stat.quotient;
        acc_sum  = {1'b0, chi_sum_reg} + {1'b0, term};
    end

    // Divider operands: bin term or reduced value.
    always_comb
    begin
        div_req.start = div_start_reg;
        if (state_reg == S_RDIV)
        begin
            div_req.rem_init = '0;
            div_req.divisor  = {{(hcsa_pkg::CONTENT_W-hcsa_pkg::REG_W){1'b0}}, dof_div};
            div_req.dividend = chi_sum_reg;
        end
        else
        begin
            div_req.rem_init = {{(hcsa_pkg::CONTENT_W-hcsa_pkg::SQ_TOP_W){1'b0}},
                                prod_reg[hcsa_pkg::PROD_W-1 -: hcsa_pkg::SQ_TOP_W]};
            div_req.divisor  = obs_reg;
            div_req.dividend = {prod_reg[hcsa_pkg::PROD_W-hcsa_pkg::SQ_TOP_W-1:0],
                                {hcsa_pkg::FRAC_SHIFT{1'b0}}};
        end
    end

    hcsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // Sequencer, configuration registers, sum and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            low_reg       <= '0;
            high_reg      <= HIGH_RESET;
            chi_sum_reg   <= '0;
            clip_reg      <= 1'b0;
            last_reg      <= 1'b0;
            obs_reg       <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            prod_reg      <= '0;
            cnt_reg       <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            reduced_reg   <= '0;
            nodof_reg     <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;

            if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    hcsa_pkg::CFG_LOW_BIN:  low_reg  <= cfg_data;
                    hcsa_pkg::CFG_HIGH_BIN: high_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (bin_pair.valid)
                    begin
                        obs_reg    <= bin_pair.observed;
                        mcand_reg  <= d_in;
                        mplier_reg <= d_in;
                        prod_reg   <= '0;
                        cnt_reg    <= '0;
                        last_reg   <= bin_pair.last_bin;
                        if (include_bin)
                        begin
                            state_reg <= S_MULT;
                        end
                        else if (bin_pair.last_bin)
                        begin
                            if (dof_ok)
                            begin
                                state_reg     <= S_RDIV;
                                div_start_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_EMIT;
                            end
                        end
                    end
                end

                S_MULT:
                begin
                    prod_reg   <= prod_next;
                    mplier_reg <= mplier_reg >> hcsa_pkg::DIGIT_W;
                    cnt_reg    <= cnt_reg + hcsa_pkg::MULT_CNT_W'(1);
                    if (cnt_reg == hcsa_pkg::MULT_CNT_W'(hcsa_pkg::MULT_STEPS - 1))
                    begin
                        state_reg     <= S_TDIV;
                        div_start_reg <= 1'b1;
                    end
                end

                S_TDIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_ACCUM;
                    end
                end

                S_ACCUM:
                begin
                    if (acc_sum[hcsa_pkg::SUM_W])
                    begin
                        chi_sum_reg <= hcsa_pkg::SUM_MAX;
                        clip_reg    <= 1'b1;
                    end
                    else
                    begin
                        chi_sum_reg <= acc_sum[hcsa_pkg::SUM_W-1:0];
                    end
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (dof_ok)
                    begin
                        state_reg     <= S_RDIV;
                        div_start_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end

                S_RDIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        total_reg     <= chi_sum_reg;
                        reduced_reg   <= dof_ok ? div_stat.quotient : '0;
                        nodof_reg     <= !dof_ok;
                        sat_reg       <= clip_reg;
                        chi_sum_reg   <= '0;
                        clip_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign bin_pair.ready               = (state_reg == S_IDLE);
    assign result.valid                 = out_valid_reg;
    assign result.total_chi_square      = total_reg;
    assign result.reduced_chi_square    = reduced_reg;
    assign result.no_degrees_of_freedom = nodof_reg;
    assign result.saturated             = sat_reg;

    // Once clipped, the sum stays pinned at its maximum until cleared.
    a_clip_pins_sum: assert property (@(posedge clk) disable iff (!rst_n)
        clip_reg |-> (chi_sum_reg == hcsa_pkg::SUM_MAX))
        else $error("clip flag set but sum is not at its maximum");

    // A result without degrees of freedom carries a zero reduced value.
    a_nodof_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.no_degrees_of_freedom) |-> (result.reduced_chi_square == '0))
        else $error("reduced value non-zero without degrees of freedom");

    // The divider is started only on entry to a division state.
    a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> ((state_reg == S_TDIV) || (state_reg == S_RDIV)))
        else $error("divider started outside a division state");

    // New items are taken only when the divider is free.
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        bin_pair.ready |-> !div_stat.busy)
        else $error("item accepted while the divider is busy");

endmodule

`default_nettype wire
